// ===== rtl/core/bpc_pkg.sv =====
package bpc_pkg;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned TIMER_BITS_DEFAULT = 16;
   localparam logic [CSR_DATA_W-1:0] LONG_PUSH_RESET = 16'd2000;
   localparam logic [CSR_DATA_W-1:0] DOUBLE_GAP_RESET = 16'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PUSH  = 1'b0,
      CSR_DOUBLE_GAP = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE          = 3'd0,
      ST_FIRST_PUSH    = 3'd1,
      ST_FIRST_RELEASE = 3'd2,
      ST_SECOND_PUSH   = 3'd3,
      ST_LONG_PUSH     = 3'd4
   } press_state_type;

   typedef enum logic [1:0] {
      EV_SINGLE = 2'd0,
      EV_DOUBLE = 2'd1,
      EV_LONG   = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
   } step_evt_type;

endpackage

// ===== rtl/core/bpc_req_if.sv =====
interface bpc_req_if;
   logic valid;
   logic ready;
   logic pressed;

   modport source (output valid, output pressed, input ready);
   modport sink (input valid, input pressed, output ready);
endinterface

// ===== rtl/core/bpc_rsp_if.sv =====
interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;

   modport source (output valid, output event_kind, input ready);
   modport sink (input valid, input event_kind, output ready);
endinterface

// ===== rtl/core/bpc_step.sv =====
module bpc_step
   import bpc_pkg::*;
#(
   parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  press_state_type         state_i,
   input  logic [TIMER_BITS-1:0]   remaining_i,
   input  logic                    running_i,
   input  logic                    pressed_i,
   input  logic [CSR_DATA_W-1:0]   long_ticks_i,
   input  logic [CSR_DATA_W-1:0]   gap_ticks_i,
   output press_state_type         state_o,
   output logic [TIMER_BITS-1:0]   remaining_o,
   output logic                    running_o,
   output step_evt_type            evt_o
);

   localparam int unsigned CMP_W = (TIMER_BITS > CSR_DATA_W) ? TIMER_BITS : CSR_DATA_W;
   localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'({TIMER_BITS{1'b1}});

   function automatic logic [TIMER_BITS-1:0] load_value(input logic [CSR_DATA_W-1:0] ticks);
      logic [CMP_W-1:0] v;
      v = CMP_W'(ticks);
      if (v == '0) begin
         v = CMP_W'(1);
      end
      if (v > TIMER_MAX) begin
         v = TIMER_MAX;
      end
      return v[TIMER_BITS-1:0];
   endfunction

   logic [TIMER_BITS-1:0] long_load;
   logic [TIMER_BITS-1:0] gap_load;
   logic [TIMER_BITS-1:0] rem_dec;
   logic                  expire;
   press_state_type       st;

   assign long_load = load_value(long_ticks_i);
   assign gap_load  = load_value(gap_ticks_i);
   assign rem_dec   = remaining_i - TIMER_BITS'(1);
   assign expire    = running_i && (rem_dec == '0);

   always_comb begin
      unique case (state_i)
         ST_IDLE, ST_FIRST_PUSH, ST_FIRST_RELEASE, ST_SECOND_PUSH, ST_LONG_PUSH: st = state_i;
         default: st = ST_IDLE;
      endcase
      remaining_o = running_i ? rem_dec : remaining_i;
      running_o   = running_i && !expire;
      evt_o.valid = 1'b0;
      evt_o.kind  = EV_SINGLE;

      // expiry comes before the level
      if (expire) begin
         if (st == ST_FIRST_PUSH || st == ST_SECOND_PUSH) begin
            st          = ST_LONG_PUSH;
            evt_o.valid = 1'b1;
            evt_o.kind  = EV_LONG;
         end else if (st == ST_FIRST_RELEASE) begin
            st          = ST_IDLE;
            evt_o.valid = 1'b1;
            evt_o.kind  = EV_SINGLE;
         end
      end

      state_o = st;
      unique case (st)
         ST_IDLE: begin
            if (pressed_i) begin
               state_o     = ST_FIRST_PUSH;
               remaining_o = long_load;
               running_o   = 1'b1;
            end
         end
         ST_FIRST_PUSH: begin
            if (!pressed_i) begin
               state_o     = ST_FIRST_RELEASE;
               remaining_o = gap_load;
               running_o   = 1'b1;
            end
         end
         ST_FIRST_RELEASE: begin
            if (pressed_i) begin
               state_o     = ST_SECOND_PUSH;
               remaining_o = long_load;
               running_o   = 1'b1;
            end
         end
         ST_SECOND_PUSH: begin
            if (!pressed_i) begin
               state_o     = ST_IDLE;
               remaining_o = '0;
               running_o   = 1'b0;
               evt_o.valid = 1'b1;
               evt_o.kind  = EV_DOUBLE;
            end
         end
         default: begin
            if (!pressed_i) begin
               state_o = ST_IDLE;
            end
         end
      endcase
   end

endmodule

// ===== rtl/core/button_press_classifier.sv =====
// channel   dir  handshake        payload
// req_chan  in   valid / ready    pressed (1 bit, one tick)
// rsp_chan  out  valid / ready    event_kind (2 bit: single, double, long)
// csr_*     in   csr_we only      csr_index (1 bit), csr_wdata (16 bit)
//
// one tick is taken per cycle unless a held result stalls it; a transfer on
// req_chan lands in the input register; any result goes to the result register
// the press state and timer advance when the input register drains into the
// result stage; a held result stalls only a tick that produces a new result
// synchronous reset returns to idle with the timer stopped and the registers
// at 2000 and 200 ticks
module button_press_classifier
   import bpc_pkg::*;
#(
   parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   bpc_req_if.sink               req_chan,
   bpc_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_pressed_ff;
   logic                  in_pressed_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   event_kind_type        out_kind_ff;
   event_kind_type        out_kind_in;
   press_state_type       state_ff;
   press_state_type       state_in;
   logic [TIMER_BITS-1:0] remaining_ff;
   logic [TIMER_BITS-1:0] remaining_in;
   logic                  running_ff;
   logic                  running_in;
   logic [CSR_DATA_W-1:0] long_ticks_ff;
   logic [CSR_DATA_W-1:0] long_ticks_in;
   logic [CSR_DATA_W-1:0] gap_ticks_ff;
   logic [CSR_DATA_W-1:0] gap_ticks_in;

   press_state_type       step_state;
   logic [TIMER_BITS-1:0] step_remaining;
   logic                  step_running;
   step_evt_type          step_evt;
   logic                  advance;

   bpc_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .state_i      (state_ff),
      .remaining_i  (remaining_ff),
      .running_i    (running_ff),
      .pressed_i    (in_pressed_ff),
      .long_ticks_i (long_ticks_ff),
      .gap_ticks_i  (gap_ticks_ff),
      .state_o      (step_state),
      .remaining_o  (step_remaining),
      .running_o    (step_running),
      .evt_o        (step_evt)
   );

   assign advance = in_valid_ff && (!step_evt.valid || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.event_kind = out_kind_ff;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_pressed_in = in_pressed_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in   = 1'b1;
         in_pressed_in = req_chan.pressed;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      if (advance && step_evt.valid) begin
         out_valid_in = 1'b1;
         out_kind_in  = step_evt.kind;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      state_in     = state_ff;
      remaining_in = remaining_ff;
      running_in   = running_ff;
      if (advance) begin
         state_in     = step_state;
         remaining_in = step_remaining;
         running_in   = step_running;
      end

      long_ticks_in = long_ticks_ff;
      gap_ticks_in  = gap_ticks_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LONG_PUSH:  long_ticks_in = csr_wdata;
            CSR_DOUBLE_GAP: gap_ticks_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= ST_IDLE;
         remaining_ff  <= '0;
         running_ff    <= 1'b0;
         long_ticks_ff <= LONG_PUSH_RESET;
         gap_ticks_ff  <= DOUBLE_GAP_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
         remaining_ff  <= remaining_in;
         running_ff    <= running_in;
         long_ticks_ff <= long_ticks_in;
         gap_ticks_ff  <= gap_ticks_in;
      end
      in_pressed_ff <= in_pressed_in;
      out_kind_ff   <= out_kind_in;
   end

   a_running_nonzero: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> remaining_ff != '0)
      else $error("timer running with zero count");

   a_rest_stopped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_LONG_PUSH) |-> !running_ff)
      else $error("timer running outside a timed state");

   a_timed_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIRST_PUSH || state_ff == ST_FIRST_RELEASE
         || state_ff == ST_SECOND_PUSH) |-> running_ff)
      else $error("timed state with timer stopped");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready && in_valid_ff && step_evt.valid) |-> !advance)
      else $error("pending result overwritten");

endmodule
